// ----- hdl/timed_task_scheduler_macros.svh -----
// Assertion macros for the timed task scheduler checker.
// Sampled on clk, the first two disabled during rst; the user module must provide both.
`ifndef TIMED_TASK_SCHEDULER_MACROS_SVH
`define TIMED_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define TTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timed_task_scheduler: check failed");

// Next-cycle implication.
`define TTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timed_task_scheduler: check failed");

// Next-cycle implication that stays live through reset.
`define TTS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("timed_task_scheduler: check failed");

`endif

// ----- hdl/tts_pkg.sv -----
// Shared types and constants of the timed task scheduler.
// Used by tts_cell, timed_task_scheduler and tts_checker; no dependencies.
`default_nettype none

package tts_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_TAG_BITS    = 8;

  // Upper bounds of the parameter ranges, for the fixed scan token layout
  localparam int TAG_W_MAX = 16;
  localparam int IDX_W_MAX = 6;

  localparam int TIME_W      = 64;
  localparam int IN_TAG_W    = 8;
  localparam int OUT_TAG_W   = 8;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int CAP_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int MAX_RESULTS = 16;
  localparam int DISP_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [CAP_W-1:0] QUEUE_CAP_RESET = CAP_W'(16);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAP = 1'b1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL_RETRY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DISPATCHED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE    = 3'd5;

  // Operation carried by a scan token through the cell row
  typedef enum logic [1:0] {
    OP_SCHED,
    OP_CANCEL,
    OP_FIND
  } scan_op_t;

  typedef struct packed {
    logic                  active;
    scan_op_t              op;
    logic [TIME_W-1:0]     key;
    logic [TAG_W_MAX-1:0]  tag;
    logic                  hit;
    logic [TIME_W-1:0]     best_time;
    logic [TAG_W_MAX-1:0]  best_tag;
    logic [IDX_W_MAX-1:0]  best_idx;
  } scan_tok_t;

  // Direct slot release after a dispatch has been chosen
  typedef struct packed {
    logic                 en;
    logic [IDX_W_MAX-1:0] idx;
  } slot_clr_t;

endpackage

`default_nettype wire

// ----- hdl/tts_cell.sv -----
// One slot of the scheduler row: holds a task and updates the passing scan token.
// Depends on tts_pkg.
`default_nettype none

module tts_cell
  import tts_pkg::*;
#(
  parameter int TAG_BITS = DEFAULT_TAG_BITS,
  parameter int CELL_IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire scan_tok_t tok_in,
  input  wire slot_clr_t clr,
  output scan_tok_t      tok_out
);

  logic                valid;
  logic [TIME_W-1:0]   due;
  logic [TAG_BITS-1:0] tag;

  scan_tok_t tok_next;
  logic      claim;
  logic      drop;
  logic      own_idx;

  assign own_idx = (clr.idx == IDX_W_MAX'(CELL_IDX));

  always_comb begin
    tok_next = tok_in;
    claim    = 1'b0;
    drop     = 1'b0;
    if (tok_in.active) begin
      case (tok_in.op)
        OP_SCHED: begin
          if (!valid && !tok_in.hit) begin
            claim             = 1'b1;
            tok_next.hit      = 1'b1;
            tok_next.best_idx = IDX_W_MAX'(CELL_IDX);
          end
        end
        OP_CANCEL: begin
          if (valid && !tok_in.hit && tag == tok_in.tag[TAG_BITS-1:0]) begin
            drop         = 1'b1;
            tok_next.hit = 1'b1;
          end
        end
        OP_FIND: begin
          // strict less-than keeps the lower slot on equal due times
          if (valid && due <= tok_in.key && (!tok_in.hit || due < tok_in.best_time)) begin
            tok_next.hit       = 1'b1;
            tok_next.best_time = due;
            tok_next.best_tag  = TAG_W_MAX'(tag);
            tok_next.best_idx  = IDX_W_MAX'(CELL_IDX);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (claim) begin
      valid <= 1'b1;
    end else if (drop || (clr.en && own_idx)) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      due <= tok_in.key;
      tag <= tok_in.tag[TAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/timed_task_scheduler.sv -----
// Timed task scheduler top level: request sequencer around a row of slot cells.
// Depends on tts_pkg and tts_cell.
//
// Use: requests arrive on the input channel (in_valid / in_stall) as items of
// kind schedule, cancel or tick; results leave on the output channel
// (out_valid / out_stall) as items of status, out_tag and last. The
// configuration channel (cfg_valid / cfg_ready, always ready) writes enable
// (index 0) and queue_cap (index 1); write it only while the block is idle.
// One item is in work at a time; in_stall is high from the accept edge until
// the last result of that item has been loaded into the output register.
// Each search walks a token through all QUEUE_DEPTH cells, one cell a cycle:
// a schedule or cancel item passes from the launch register through every
// cell to the result registers and is loaded into the output register from
// the resolve state; a refused schedule loads its result from the reply state.
// The next item can be taken in the cycle after the load. A tick makes one
// pass for each due task plus one more pass to find that nothing else is due
// (none once 16 are dispatched). Kind 3 is dropped with no result.
// Reset empties all slots, clears the pending count, disables scheduling and
// sets queue_cap to 16. While the receiver stalls, the output register holds
// its item and the sequence waits before loading the next result.
`default_nettype none

module timed_task_scheduler
  import tts_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEFAULT_TAG_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [IN_TAG_W-1:0]   task_tag,
  input  wire logic [TIME_W-1:0]     due_time,
  input  wire logic [TIME_W-1:0]     now,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [OUT_TAG_W-1:0]       out_tag,
  output logic                       last,
  // configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_REPLY
  } state_t;

  state_t state;

  // configuration registers
  logic             enable;
  logic [CAP_W-1:0] queue_cap;

  // request context
  scan_op_t            op_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [TIME_W-1:0]   key_q;
  logic [CNT_W-1:0]    count;
  logic [DISP_W-1:0]   n_disp;
  logic                have_hold;
  logic [TAG_BITS-1:0] hold_tag;

  // outcome of the last pass through the row
  logic                res_hit;
  logic [TAG_BITS-1:0] res_tag;
  logic [IDX_W-1:0]    res_idx;

  // single pending result for the reply state
  logic [STATUS_W-1:0]  reply_status;
  logic [OUT_TAG_W-1:0] reply_tag;

  scan_tok_t launch;
  scan_tok_t tok [QUEUE_DEPTH+1];
  scan_tok_t tok_end;
  slot_clr_t clr;

  logic                tag_in;
  logic [TAG_BITS-1:0] tag_m;
  logic [CMP_W-1:0]    cap_eff;
  logic                full;
  logic                out_free;
  logic                out_load;

  function automatic scan_tok_t mk_tok(scan_op_t op, logic [TIME_W-1:0] key,
                                       logic [TAG_BITS-1:0] t);
    scan_tok_t r;
    r           = '0;
    r.active    = 1'b1;
    r.op        = op;
    r.key       = key;
    r.tag       = TAG_W_MAX'(t);
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // tags only keep their low TAG_BITS
  assign tag_m  = TAG_BITS'(task_tag);
  assign tag_in = in_valid && !in_stall;

  // effective capacity never exceeds the slot count
  assign cap_eff = (CMP_W'(queue_cap) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                             : CMP_W'(queue_cap);
  assign full    = (CMP_W'(count) >= cap_eff);

  // load a result into the output register this cycle
  always_comb begin
    case (state)
      S_RESOLVE: out_load = out_free && ((op_q == OP_SCHED) || (op_q == OP_CANCEL) ||
                                         ((op_q == OP_FIND) && (!res_hit || have_hold)));
      S_REPLY:   out_load = out_free;
      default:   out_load = 1'b0;
    endcase
  end

  // release the chosen slot at the same edge the next search, if any, is launched
  always_comb begin
    clr.en  = (state == S_RESOLVE) && out_free && (op_q == OP_FIND) && res_hit;
    clr.idx = IDX_W_MAX'(res_idx);
  end

  // cell row
  assign tok[0]  = launch;
  assign tok_end = tok[QUEUE_DEPTH];

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    tts_cell #(
      .TAG_BITS (TAG_BITS),
      .CELL_IDX (gi)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[gi]),
      .clr     (clr),
      .tok_out (tok[gi+1])
    );
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      queue_cap <= QUEUE_CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_QUEUE_CAP: queue_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  // request sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      count         <= '0;
      have_hold     <= 1'b0;
      launch.active <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tag_in) begin
            tag_q     <= tag_m;
            n_disp    <= '0;
            have_hold <= 1'b0;
            case (kind)
              KIND_SCHEDULE: begin
                op_q  <= OP_SCHED;
                key_q <= due_time;
                if (!enable) begin
                  reply_status <= ST_NOT_RUNNING;
                  reply_tag    <= OUT_TAG_W'(tag_m);
                  state        <= S_REPLY;
                end else if (full) begin
                  reply_status <= ST_FULL_RETRY;
                  reply_tag    <= OUT_TAG_W'(tag_m);
                  state        <= S_REPLY;
                end else begin
                  launch <= mk_tok(OP_SCHED, due_time, tag_m);
                  state  <= S_SCAN;
                end
              end
              KIND_CANCEL: begin
                op_q   <= OP_CANCEL;
                key_q  <= due_time;
                launch <= mk_tok(OP_CANCEL, due_time, tag_m);
                state  <= S_SCAN;
              end
              KIND_TICK: begin
                op_q   <= OP_FIND;
                key_q  <= now;
                launch <= mk_tok(OP_FIND, now, tag_m);
                state  <= S_SCAN;
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          // the first cell has taken the token; drop it from the launch register
          launch.active <= 1'b0;
          // wait for the token to leave the last cell
          if (tok_end.active) begin
            res_hit <= tok_end.hit;
            res_tag <= tok_end.best_tag[TAG_BITS-1:0];
            res_idx <= tok_end.best_idx[IDX_W-1:0];
            state   <= S_RESOLVE;
          end
        end

        S_RESOLVE: begin
          if (out_free) begin
            case (op_q)
              OP_SCHED: begin
                status    <= res_hit ? ST_ACCEPTED : ST_FULL_RETRY;
                out_tag   <= OUT_TAG_W'(tag_q);
                last      <= 1'b1;
                if (res_hit) begin
                  count <= count + CNT_W'(1);
                end
                state <= S_IDLE;
              end
              OP_CANCEL: begin
                status    <= res_hit ? ST_ACCEPTED : ST_NOT_FOUND;
                out_tag   <= OUT_TAG_W'(tag_q);
                last      <= 1'b1;
                if (res_hit) begin
                  count <= count - CNT_W'(1);
                end
                state <= S_IDLE;
              end
              OP_FIND: begin
                if (res_hit) begin
                  count  <= count - CNT_W'(1);
                  n_disp <= n_disp + DISP_W'(1);
                  // the held dispatch is not the final one
                  if (have_hold) begin
                    status    <= ST_DISPATCHED;
                    out_tag   <= OUT_TAG_W'(hold_tag);
                    last      <= 1'b0;
                  end
                  if (n_disp == DISP_W'(MAX_RESULTS - 1)) begin
                    // result limit reached: this one closes the tick
                    have_hold    <= 1'b0;
                    reply_status <= ST_DISPATCHED;
                    reply_tag    <= OUT_TAG_W'(res_tag);
                    state        <= S_REPLY;
                  end else begin
                    hold_tag  <= res_tag;
                    have_hold <= 1'b1;
                    launch    <= mk_tok(OP_FIND, key_q, tag_q);
                    state     <= S_SCAN;
                  end
                end else begin
                  status    <= have_hold ? ST_DISPATCHED : ST_NONE_DUE;
                  out_tag   <= have_hold ? OUT_TAG_W'(hold_tag) : '0;
                  last      <= 1'b1;
                  have_hold <= 1'b0;
                  state     <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_REPLY: begin
          if (out_free) begin
            status    <= reply_status;
            out_tag   <= reply_tag;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tts_checker.sv -----
// Port-level checks of the timed task scheduler, bound to the top level.
// Depends on tts_pkg and timed_task_scheduler_macros.svh.
`default_nettype none

`include "timed_task_scheduler_macros.svh"

module tts_checker
  import tts_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [KIND_W-1:0]     kind,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [STATUS_W-1:0]   status,
  input wire logic [OUT_TAG_W-1:0]  out_tag,
  input wire logic                  last
);

  // a real request keeps the block busy in the following cycle
  `TTS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall && kind != KIND_UNUSED, in_stall)

  // only dispatches may be followed by further results of the same item
  `TTS_ASSERT_IMP(a_single_has_last, out_valid && status != ST_DISPATCHED, last)

  // a tick with nothing due reports tag zero
  `TTS_ASSERT_IMP(a_none_due_tag, out_valid && status == ST_NONE_DUE, out_tag == '0)

  // a stalled result holds
  `TTS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(out_tag) && $stable(last))

  // reset empties the output register
  `TTS_ASSERT_RST(a_reset_out, rst, !out_valid)

endmodule

bind timed_task_scheduler tts_checker u_tts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .kind      (kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_tag   (out_tag),
  .last      (last)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for timed_task_scheduler: drives schedule, cancel, tick and unused items,
// predicts every result in a behavioural model of the slot store, and checks each one.
// Depends on tts_pkg and the timed_task_scheduler RTL only.
`timescale 1ns / 100ps

module testbench;
  import tts_pkg::*;

  localparam int DEPTH         = DEFAULT_QUEUE_DEPTH;
  localparam int SETTLE_CYCLES = 2 * (DEPTH + 2);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_TAG_W-1:0] tag;
    logic                 last;
  } outcome_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     kind;
  logic [IN_TAG_W-1:0]   task_tag;
  logic [TIME_W-1:0]     due_time;
  logic [TIME_W-1:0]     now;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [OUT_TAG_W-1:0]  out_tag;
  logic                  last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  timed_task_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .task_tag  (task_tag),
    .due_time  (due_time),
    .now       (now),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_tag   (out_tag),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the scheduler: slot store, pending count and the two registers
  logic                 slot_busy [DEPTH];
  logic [TIME_W-1:0]    slot_due  [DEPTH];
  logic [OUT_TAG_W-1:0] slot_tag  [DEPTH];
  int unsigned          pending_tasks;
  logic                 run_enable;
  logic [CAP_W-1:0]     cap_setting;

  // Results still owed by the block, oldest first
  outcome_t awaited_outcomes[$];

  int unsigned error_count;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  logic [TIME_W-1:0] time_window;

  // 10 ns clock
  always #5 clk = ~clk;

  // Hold the receiver off at random; the percentage sets the phase
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0d ns: MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Result monitor: pop the oldest expectation for every accepted result
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        want = awaited_outcomes.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (out_tag !== want.tag)   report_mismatch("out_tag", out_tag, want.tag);
        if (last !== want.last)     report_mismatch("last", last, want.last);
      end
    end
  end

  // Clear the shadow store as reset does
  task automatic reset_shadow();
    for (int i = 0; i < DEPTH; i++) begin
      slot_busy[i] = 1'b0;
      slot_due[i]  = '0;
      slot_tag[i]  = '0;
    end
    pending_tasks = 0;
    run_enable    = 1'b0;
    cap_setting   = QUEUE_CAP_RESET;
  endtask

  function automatic outcome_t make_outcome(input logic [STATUS_W-1:0] st,
                                            input logic [OUT_TAG_W-1:0] tg,
                                            input logic lst);
    outcome_t o;
    o.status = st;
    o.tag    = tg;
    o.last   = lst;
    return o;
  endfunction

  // Work out the results of one accepted item and update the shadow store
  task automatic apply_request(input logic [KIND_W-1:0] k, input logic [IN_TAG_W-1:0] tg,
                               input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] tnow);
    int unsigned cap_eff;
    int          pick;
    int          sent;
    logic        done;
    cap_eff = (cap_setting > DEPTH) ? DEPTH : cap_setting;
    done    = 1'b0;
    sent    = 0;
    case (k)
      KIND_SCHEDULE: begin
        if (!run_enable) begin
          awaited_outcomes.push_back(make_outcome(ST_NOT_RUNNING, tg, 1'b1));
        end else if (pending_tasks >= cap_eff) begin
          awaited_outcomes.push_back(make_outcome(ST_FULL_RETRY, tg, 1'b1));
        end else begin
          // take the lowest free slot
          for (int i = 0; i < DEPTH && !done; i++) begin
            if (!slot_busy[i]) begin
              slot_busy[i] = 1'b1;
              slot_due[i]  = due;
              slot_tag[i]  = tg;
              pending_tasks++;
              done = 1'b1;
            end
          end
          awaited_outcomes.push_back(make_outcome(done ? ST_ACCEPTED : ST_FULL_RETRY,
                                                  tg, 1'b1));
        end
      end
      KIND_CANCEL: begin
        // only the lowest matching slot goes; the enable has no say here
        for (int i = 0; i < DEPTH && !done; i++) begin
          if (slot_busy[i] && slot_tag[i] == tg) begin
            slot_busy[i] = 1'b0;
            pending_tasks--;
            done = 1'b1;
          end
        end
        awaited_outcomes.push_back(make_outcome(done ? ST_ACCEPTED : ST_NOT_FOUND,
                                                tg, 1'b1));
      end
      KIND_TICK: begin
        // dispatch due tasks, earliest first, ties to the lowest slot
        while (sent < MAX_RESULTS && !done) begin
          pick = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (slot_busy[i] && slot_due[i] <= tnow) begin
              if (pick < 0 || slot_due[i] < slot_due[pick]) pick = i;
            end
          end
          if (pick < 0) begin
            done = 1'b1;
          end else begin
            slot_busy[pick] = 1'b0;
            pending_tasks--;
            awaited_outcomes.push_back(make_outcome(ST_DISPATCHED, slot_tag[pick], 1'b0));
            sent++;
          end
        end
        if (sent == 0)
          awaited_outcomes.push_back(make_outcome(ST_NONE_DUE, '0, 1'b1));
        else
          awaited_outcomes[awaited_outcomes.size() - 1].last = 1'b1;
      end
      default: ;  // unused kind: dropped, nothing owed
    endcase
  endtask

  // Present one item after a random idle gap and hold it until taken
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [IN_TAG_W-1:0] tg,
                           input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] tnow);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    task_tag <= tg;
    due_time <= due;
    now      <= tnow;
    do @(posedge clk); while (in_stall);
    apply_request(k, tg, due, tnow);
  endtask

  // Drop the request line and let every owed result arrive, then settle
  task automatic drain_outcomes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; only called with the block idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ENABLE) run_enable = data[0];
    else                   cap_setting = data[CAP_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(9))
      0:       return '0;
      1:       return TIME_MAX;
      2, 3:    return {$urandom, $urandom};
      default: return time_window + $urandom_range(63);
    endcase
  endfunction

  function automatic logic [IN_TAG_W-1:0] pick_tag();
    if ($urandom_range(1) == 0) return IN_TAG_W'($urandom_range(7));
    return IN_TAG_W'($urandom_range(255));
  endfunction

  // Out of reset: disabled, nothing pending, unused kind ignored
  task automatic test_reset_defaults();
    send_item(KIND_SCHEDULE, 8'hFF, TIME_MAX, '0);
    send_item(KIND_TICK, 8'h00, '0, '0);
    send_item(KIND_CANCEL, 8'h00, '0, TIME_MAX);
    send_item(KIND_UNUSED, 8'hA5, TIME_MAX, TIME_MAX);
    drain_outcomes();
  endtask

  // Capacity zero refuses everything; capacity one takes a single task
  task automatic test_capacity_limits();
    write_register(REG_ENABLE, CFG_DATA_W'(1));
    write_register(REG_QUEUE_CAP, CFG_DATA_W'(0));
    send_item(KIND_SCHEDULE, 8'h00, 64'd5, '0);
    drain_outcomes();
    write_register(REG_QUEUE_CAP, CFG_DATA_W'(1));
    send_item(KIND_SCHEDULE, 8'h5A, 64'd100, '0);
    send_item(KIND_SCHEDULE, 8'h5B, 64'd100, '0);
    send_item(KIND_TICK, 8'h00, '0, 64'd99);
    send_item(KIND_TICK, 8'h00, '0, 64'd100);
    drain_outcomes();
  endtask

  // Capacity above depth, duplicate tags, equal due times
  task automatic test_dispatch_order();
    write_register(REG_QUEUE_CAP, CFG_DATA_W'(31));
    send_item(KIND_SCHEDULE, 8'h07, TIME_MAX, '0);
    send_item(KIND_SCHEDULE, 8'h07, 64'd0, '0);
    send_item(KIND_SCHEDULE, 8'h03, 64'd0, '0);
    send_item(KIND_SCHEDULE, 8'hFF, 64'd1, '0);
    send_item(KIND_SCHEDULE, 8'h80, 64'd2, '0);
    send_item(KIND_CANCEL, 8'h07, '0, '0);
    send_item(KIND_CANCEL, 8'h09, '0, '0);
    send_item(KIND_TICK, 8'h00, '0, 64'd0);
    drain_outcomes();
  endtask

  // Disabled: schedule refused, cancel and tick still served
  task automatic test_disabled_service();
    write_register(REG_ENABLE, CFG_DATA_W'(0));
    send_item(KIND_SCHEDULE, 8'h11, 64'd3, '0);
    send_item(KIND_CANCEL, 8'h80, '0, '0);
    send_item(KIND_TICK, 8'h00, '0, TIME_MAX);
    drain_outcomes();
  endtask

  // One idle phase: a fill burst, then mixed traffic around a time window
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    int          live[$];
    int unsigned choice;
    sender_idle_pct = send_pct;
    stall_pct       = recv_pct;
    time_window     = {$urandom, $urandom};
    write_register(REG_ENABLE, CFG_DATA_W'(1));
    case ($urandom_range(2))
      0:       write_register(REG_QUEUE_CAP, CFG_DATA_W'(DEPTH));
      1:       write_register(REG_QUEUE_CAP, CFG_DATA_W'(31));
      default: write_register(REG_QUEUE_CAP, CFG_DATA_W'($urandom_range(31)));
    endcase
    // fill past the limit, then clear the lot in one tick
    repeat (DEPTH + 1) send_item(KIND_SCHEDULE, pick_tag(), pick_time(), '0);
    send_item(KIND_TICK, 8'h00, '0, TIME_MAX);
    drain_outcomes();
    write_register(REG_QUEUE_CAP, CFG_DATA_W'($urandom_range(31)));
    write_register(REG_ENABLE, CFG_DATA_W'($urandom_range(3) != 0));
    repeat (50) begin
      choice = $urandom_range(99);
      if (choice < 45) begin
        send_item(KIND_SCHEDULE, pick_tag(), pick_time(), {$urandom, $urandom});
      end else if (choice < 65) begin
        // mostly cancel a task that is really pending
        live.delete();
        for (int i = 0; i < DEPTH; i++) if (slot_busy[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(9) < 7)
          send_item(KIND_CANCEL, slot_tag[live[$urandom_range(live.size() - 1)]],
                    {$urandom, $urandom}, {$urandom, $urandom});
        else
          send_item(KIND_CANCEL, pick_tag(), {$urandom, $urandom}, {$urandom, $urandom});
      end else if (choice < 95) begin
        send_item(KIND_TICK, IN_TAG_W'($urandom_range(255)), {$urandom, $urandom},
                  pick_time());
      end else begin
        send_item(KIND_UNUSED, IN_TAG_W'($urandom_range(255)), {$urandom, $urandom},
                  {$urandom, $urandom});
      end
    end
    drain_outcomes();
  endtask

  initial begin
    // Drive every input to a known value before the first edge
    clk             = 1'b0;
    rst             = 1'b1;
    in_valid        = 1'b0;
    kind            = KIND_SCHEDULE;
    task_tag        = '0;
    due_time        = '0;
    now             = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_ENABLE;
    cfg_data        = '0;
    error_count     = 0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    time_window     = '0;
    reset_shadow();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_capacity_limits();
    test_dispatch_order();
    test_disabled_service();
    test_random_traffic(0, 0);
    test_random_traffic(79, 0);
    test_random_traffic(0, 79);
    test_random_traffic(11, 11);

    if (error_count == 0) begin
      $display("timed_task_scheduler verification clean");
    end else begin
      $display("timed_task_scheduler verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timed_task_scheduler verification failed");
    $finish;
  end

endmodule

// ----- timed_task_scheduler.f -----
+incdir+hdl
hdl/tts_pkg.sv
hdl/tts_cell.sv
hdl/timed_task_scheduler.sv
hdl/tts_checker.sv
tb/testbench.sv
